// ===== hdl/pid_altitude_rate_controller_macros.svh =====
// Assertion macros shared by the altitude rate controller RTL.
`ifndef PID_ALTITUDE_RATE_CONTROLLER_MACROS_SVH
`define PID_ALTITUDE_RATE_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define PIDAR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pidar: property violated");
// Condition must never be seen outside reset.
`define PIDAR_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("pidar: forbidden condition seen");
`else
`define PIDAR_ASSERT(lbl, prop)
`define PIDAR_NEVER(lbl, cond)
`endif

`endif

// ===== hdl/pidar_pkg.sv =====
// Types, constants and register map of the altitude rate controller.
`timescale 1ns / 1ps

package pidar_pkg;

  // Register map (byte address = 4 * index)
  localparam int unsigned RegAddrW = 5;
  localparam logic [2:0] RegTarget   = 3'd0;
  localparam logic [2:0] RegGainP    = 3'd1;
  localparam logic [2:0] RegGainI    = 3'd2;
  localparam logic [2:0] RegGainD    = 3'd3;
  localparam logic [2:0] RegMaxVel   = 3'd4;
  localparam logic [2:0] RegIntLimit = 3'd5;

  // Reset values of the registers
  localparam logic [30:0] TargetReset   = 31'd32768;
  localparam logic [23:0] GainPReset    = 24'd65536;
  localparam logic [23:0] GainIReset    = 24'd13107;
  localparam logic [23:0] GainDReset    = 24'd19661;
  localparam logic [30:0] MaxVelReset   = 31'd32768;
  localparam logic [30:0] IntLimitReset = 31'd131072;

  // Time step handling: 0.02 s replaces a zero step or one above 1.0 s
  localparam logic [16:0] DtDefault = 17'd1311;
  localparam logic [31:0] DtMax     = 32'd65536;

  // Derivative divider: 32-bit magnitude shifted up by 16
  localparam int unsigned DivSteps = 48;
  localparam int unsigned CntW     = $clog2(DivSteps);

  // Saturation bounds of the derivative
  localparam logic [31:0] DerivMax = 32'h7FFF_FFFF;
  localparam logic [31:0] DerivMin = 32'h8000_0000;

  typedef struct packed {
    logic [30:0] target_altitude;
    logic [23:0] gain_p;
    logic [23:0] gain_i;
    logic [23:0] gain_d;
    logic [30:0] max_velocity;
    logic [30:0] integral_limit;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERRDT,
    ST_INTEG,
    ST_DIV,
    ST_DERIV,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_SUM,
    ST_FINISH
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ERRDT,
    OP_INTEG,
    OP_DIV,
    OP_DERIV,
    OP_MUL_P,
    OP_MUL_I,
    OP_MUL_D,
    OP_SUM,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;  // divider performs its final step this cycle
    logic out_free;  // output register can take a new result
  } dp_stat_t;

endpackage

// ===== hdl/pidar_regs.sv =====
// APB configuration registers of the altitude rate controller.
`timescale 1ns / 1ps

module pidar_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pidar_pkg::RegAddrW-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output pidar_pkg::cfg_t                  cfg_o
);
  import pidar_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[RegAddrW-1:2];
  assign cfg_o  = cfg_q;

  // Register write decode; unmapped indexes are ignored
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegTarget:   cfg_d.target_altitude = pwdata[30:0];
        RegGainP:    cfg_d.gain_p          = pwdata[23:0];
        RegGainI:    cfg_d.gain_i          = pwdata[23:0];
        RegGainD:    cfg_d.gain_d          = pwdata[23:0];
        RegMaxVel:   cfg_d.max_velocity    = pwdata[30:0];
        RegIntLimit: cfg_d.integral_limit  = pwdata[30:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_altitude <= TargetReset;
      cfg_q.gain_p          <= GainPReset;
      cfg_q.gain_i          <= GainIReset;
      cfg_q.gain_d          <= GainDReset;
      cfg_q.max_velocity    <= MaxVelReset;
      cfg_q.integral_limit  <= IntLimitReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux; the setpoint reads back sign extended
  always_comb begin
    case (idx)
      RegTarget:   prdata = {cfg_q.target_altitude[30], cfg_q.target_altitude};
      RegGainP:    prdata = {8'd0, cfg_q.gain_p};
      RegGainI:    prdata = {8'd0, cfg_q.gain_i};
      RegGainD:    prdata = {8'd0, cfg_q.gain_d};
      RegMaxVel:   prdata = {1'b0, cfg_q.max_velocity};
      RegIntLimit: prdata = {1'b0, cfg_q.integral_limit};
      default:     prdata = 32'd0;
    endcase
  end

endmodule

// ===== hdl/pidar_ctrl.sv =====
// Sequencer of the altitude rate controller: steps the datapath per item.
`timescale 1ns / 1ps

module pidar_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pidar_pkg::dp_stat_t stat_i,
  output pidar_pkg::dp_cmd_t  cmd_o
);
  import pidar_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath command
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_ERRDT;
        end
      end
      ST_ERRDT: begin
        cmd_o.op = OP_ERRDT;
        state_d  = ST_INTEG;
      end
      ST_INTEG: begin
        cmd_o.op = OP_INTEG;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV;
        if (stat_i.div_last) begin
          state_d = ST_DERIV;
        end
      end
      ST_DERIV: begin
        cmd_o.op = OP_DERIV;
        state_d  = ST_MUL_P;
      end
      ST_MUL_P: begin
        cmd_o.op = OP_MUL_P;
        state_d  = ST_MUL_I;
      end
      ST_MUL_I: begin
        cmd_o.op = OP_MUL_I;
        state_d  = ST_MUL_D;
      end
      ST_MUL_D: begin
        cmd_o.op = OP_MUL_D;
        state_d  = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.op = OP_SUM;
        state_d  = ST_FINISH;
      end
      ST_FINISH: begin
        // wait here while the previous result is still held
        if (stat_i.out_free) begin
          cmd_o.op = OP_FINISH;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/pidar_dp.sv =====
// Datapath: error, integral, serial divider, shared multiplier, output register.
`timescale 1ns / 1ps

module pidar_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pidar_pkg::cfg_t     cfg_i,
  input  pidar_pkg::dp_cmd_t  cmd_i,
  output pidar_pkg::dp_stat_t stat_o,
  input  logic signed [30:0]  measured_altitude_i,
  input  logic [31:0]         elapsed_time_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  velocity_command_o,
  output logic                dt_replaced_o,
  output logic                integral_clamped_o,
  output logic                output_clamped_o
);
  import pidar_pkg::*;

  // Per-item working registers
  logic signed [31:0] err_q, err_d;
  logic [16:0]        dt_q, dt_d;
  logic               dt_rep_q, dt_rep_d;
  logic               int_hit_q, int_hit_d;
  logic               diff_neg_q, diff_neg_d;
  logic [47:0]        quo_q, quo_d;
  logic [16:0]        rem_q, rem_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic signed [31:0] deriv_q, deriv_d;
  logic signed [56:0] prod_q, prod_d;
  logic signed [58:0] acc_q, acc_d;

  // Controller state kept across items
  logic signed [31:0] integ_q, integ_d;
  logic signed [31:0] last_err_q, last_err_d;

  // Output register
  logic               out_valid_q, out_valid_d;
  logic signed [31:0] cmd_q, cmd_d;
  logic               out_rep_q, out_rep_d;
  logic               out_ihit_q, out_ihit_d;
  logic               out_ohit_q, out_ohit_d;

  // Shared multiplier
  logic signed [24:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [56:0] mul_p;

  // Helpers
  logic               dt_bad;
  logic signed [32:0] diff;
  logic [32:0]        diff_mag;
  logic signed [33:0] isum;
  logic signed [33:0] ilim;
  logic [17:0]        trial;
  logic               trial_ge;
  logic               sat_pos, sat_neg;
  logic signed [42:0] cmd_full;
  logic signed [42:0] vlim;
  logic signed [58:0] prod_ext;

  assign dt_bad   = (elapsed_time_i == 32'd0) || (elapsed_time_i > DtMax);
  assign diff     = {err_q[31], err_q} - {last_err_q[31], last_err_q};
  assign diff_mag = diff[32] ? (33'd0 - diff) : diff;
  assign isum     = {{2{integ_q[31]}}, integ_q} + {prod_q[48], prod_q[48:16]};
  assign ilim     = {3'd0, cfg_i.integral_limit};
  assign trial    = {rem_q, quo_q[47]};
  assign trial_ge = trial >= {1'b0, dt_q};
  assign sat_pos  = |quo_q[47:31];
  assign sat_neg  = (|quo_q[47:32]) || (quo_q[31] && (|quo_q[30:0]));
  assign cmd_full = acc_q[58:16];
  assign vlim     = {12'd0, cfg_i.max_velocity};
  assign prod_ext = {{2{prod_q[56]}}, prod_q};

  // Multiplier operand select
  always_comb begin
    case (cmd_i.op)
      OP_ERRDT: begin
        mul_a = {8'd0, dt_q};
        mul_b = err_q;
      end
      OP_MUL_P: begin
        mul_a = {1'b0, cfg_i.gain_p};
        mul_b = err_q;
      end
      OP_MUL_I: begin
        mul_a = {1'b0, cfg_i.gain_i};
        mul_b = integ_q;
      end
      OP_MUL_D: begin
        mul_a = {1'b0, cfg_i.gain_d};
        mul_b = deriv_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign stat_o.div_last = (cnt_q == CntW'(DivSteps - 1));
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  // Next-state logic per datapath operation
  always_comb begin
    err_d       = err_q;
    dt_d        = dt_q;
    dt_rep_d    = dt_rep_q;
    int_hit_d   = int_hit_q;
    diff_neg_d  = diff_neg_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    deriv_d     = deriv_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    integ_d     = integ_q;
    last_err_d  = last_err_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_d       = cmd_q;
    out_rep_d   = out_rep_q;
    out_ihit_d  = out_ihit_q;
    out_ohit_d  = out_ohit_q;
    case (cmd_i.op)
      OP_LOAD: begin
        // error and sanitized time step of the accepted transaction
        err_d = {cfg_i.target_altitude[30], cfg_i.target_altitude}
              - {measured_altitude_i[30], measured_altitude_i};
        if (dt_bad) begin
          dt_d     = DtDefault;
          dt_rep_d = 1'b1;
        end else begin
          dt_d     = elapsed_time_i[16:0];
          dt_rep_d = 1'b0;
        end
      end
      OP_ERRDT: begin
        // err*dt product; arm the divider with |diff| << 16
        prod_d     = mul_p;
        diff_neg_d = diff[32];
        quo_d      = {diff_mag[31:0], 16'd0};
        rem_d      = '0;
        cnt_d      = '0;
        last_err_d = err_q;
      end
      OP_INTEG: begin
        // integral update with anti-windup clamp
        if (isum > ilim) begin
          integ_d   = ilim[31:0];
          int_hit_d = 1'b1;
        end else if (isum < -ilim) begin
          integ_d   = 32'd0 - ilim[31:0];
          int_hit_d = 1'b1;
        end else begin
          integ_d   = isum[31:0];
          int_hit_d = 1'b0;
        end
      end
      OP_DIV: begin
        // one restoring division step
        if (trial_ge) begin
          rem_d = 17'(trial - {1'b0, dt_q});
        end else begin
          rem_d = trial[16:0];
        end
        quo_d = {quo_q[46:0], trial_ge};
        cnt_d = cnt_q + 1'b1;
      end
      OP_DERIV: begin
        // sign the truncated quotient and saturate to 32 bits
        if (diff_neg_q) begin
          deriv_d = sat_neg ? DerivMin : (32'd0 - quo_q[31:0]);
        end else begin
          deriv_d = sat_pos ? DerivMax : {1'b0, quo_q[30:0]};
        end
      end
      OP_MUL_P: begin
        prod_d = mul_p;
      end
      OP_MUL_I: begin
        prod_d = mul_p;
        acc_d  = prod_ext;
      end
      OP_MUL_D: begin
        prod_d = mul_p;
        acc_d  = acc_q + prod_ext;
      end
      OP_SUM: begin
        acc_d = acc_q + prod_ext;
      end
      OP_FINISH: begin
        // floor to Q16.16 and clamp to the velocity limit
        if (cmd_full > vlim) begin
          cmd_d      = vlim[31:0];
          out_ohit_d = 1'b1;
        end else if (cmd_full < -vlim) begin
          cmd_d      = 32'd0 - vlim[31:0];
          out_ohit_d = 1'b1;
        end else begin
          cmd_d      = cmd_full[31:0];
          out_ohit_d = 1'b0;
        end
        out_rep_d   = dt_rep_q;
        out_ihit_d  = int_hit_q;
        out_valid_d = 1'b1;
      end
      default: begin
        out_valid_d = out_valid_q && out_stall_i;
      end
    endcase
  end

  // Control and loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      integ_q     <= '0;
      last_err_q  <= '0;
      cnt_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      integ_q     <= integ_d;
      last_err_q  <= last_err_d;
      cnt_q       <= cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    err_q      <= err_d;
    dt_q       <= dt_d;
    dt_rep_q   <= dt_rep_d;
    int_hit_q  <= int_hit_d;
    diff_neg_q <= diff_neg_d;
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    deriv_q    <= deriv_d;
    prod_q     <= prod_d;
    acc_q      <= acc_d;
    cmd_q      <= cmd_d;
    out_rep_q  <= out_rep_d;
    out_ihit_q <= out_ihit_d;
    out_ohit_q <= out_ohit_d;
  end

  assign out_valid_o        = out_valid_q;
  assign velocity_command_o = cmd_q;
  assign dt_replaced_o      = out_rep_q;
  assign integral_clamped_o = out_ihit_q;
  assign output_clamped_o   = out_ohit_q;

endmodule

// ===== hdl/pid_altitude_rate_controller.sv =====
// Top level of the PID altitude rate controller with integral anti-windup.
//
// Input channel: measured_altitude_i (signed Q15.16) and elapsed_time_i
// (unsigned Q16.16 s); a transaction is taken when in_valid_i is high and
// in_stall_o is low. Output channel: velocity_command_o with the flags
// dt_replaced_o, integral_clamped_o, output_clamped_o, taken when
// out_valid_o is high and out_stall_i is low. Gains, setpoint and limits
// sit behind an APB port at byte addresses 0x00 to 0x14.
// Each item runs, one at a time: load, err*dt product, integral, the
// 48-step restoring divider for the derivative, three gain products, sum
// and output clamp; the 25x32 multiplier is shared by the four products.
// in_stall_o is low only while the sequencer is idle.
// The output register holds a finished result while the receiver stalls,
// and the next item is accepted meanwhile; if that item finishes before
// the held result is taken, it waits in its last step.
// Reset: integral and last error clear to zero, registers take their
// default values, no result is pending.
`timescale 1ns / 1ps

module pid_altitude_rate_controller (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [30:0]                  measured_altitude_i,
  input  logic [31:0]                         elapsed_time_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [31:0]                  velocity_command_o,
  output logic                                dt_replaced_o,
  output logic                                integral_clamped_o,
  output logic                                output_clamped_o,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pidar_pkg::RegAddrW-1:0]      paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import pidar_pkg::*;

`include "pid_altitude_rate_controller_macros.svh"

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  pidar_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pidar_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pidar_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .measured_altitude_i (measured_altitude_i),
    .elapsed_time_i      (elapsed_time_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .velocity_command_o  (velocity_command_o),
    .dt_replaced_o       (dt_replaced_o),
    .integral_clamped_o  (integral_clamped_o),
    .output_clamped_o    (output_clamped_o)
  );

  // Velocity limit as a signed value for the checks below
  logic signed [31:0] vmax_s;
  assign vmax_s = {1'b0, cfg.max_velocity};

  // The sequencer is busy right after it takes a transaction
  `PIDAR_ASSERT(a_busy_after_accept, (in_valid_i && !in_stall_o) |=> in_stall_o)
  // A new result only appears at the end of the work on an item
  `PIDAR_ASSERT(a_result_after_work, $rose(out_valid_o) |-> $past(in_stall_o))
  // A delivered command never exceeds the velocity limit
  `PIDAR_ASSERT(a_cmd_in_range,
    out_valid_o |-> ((velocity_command_o <= vmax_s) && (velocity_command_o >= -vmax_s)))
  // A clamped command sits exactly on the limit
  `PIDAR_ASSERT(a_clamp_on_limit, (out_valid_o && output_clamped_o) |->
    ((velocity_command_o == vmax_s) || (velocity_command_o == -vmax_s)))

endmodule
